// ===== sv/urfp_pkg.sv =====
package urfp_pkg;

    // field widths
    localparam int BYTE_W    = 8;
    localparam int POS_W     = 3;
    localparam int OUT_DATA_W = 48;

    // request kinds carried in tuser
    localparam logic OP_RX_BYTE = 1'b0;
    localparam logic OP_POLL    = 1'b1;

    // configuration register indexes
    localparam logic CFG_HEADER_FIRST  = 1'b0;
    localparam logic CFG_HEADER_SECOND = 1'b1;

    // configuration reset values
    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'h47;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h4f;

    // frame parser states, one-hot
    typedef enum logic [7:0] {
        ST_HDR1   = 8'b0000_0001,
        ST_HDR2   = 8'b0000_0010,
        ST_X      = 8'b0000_0100,
        ST_Y      = 8'b0000_1000,
        ST_GRIP   = 8'b0001_0000,
        ST_WEIGHT = 8'b0010_0000,
        ST_SKIP   = 8'b0100_0000,
        ST_CHECK  = 8'b1000_0000
    } t_frame_state;

    // frame parser state as its position in the frame
    function automatic logic [POS_W-1:0] state_pos(input t_frame_state st);
        logic [POS_W-1:0] pos;
        case (st)
            ST_HDR1:   pos = 3'd0;
            ST_HDR2:   pos = 3'd1;
            ST_X:      pos = 3'd2;
            ST_Y:      pos = 3'd3;
            ST_GRIP:   pos = 3'd4;
            ST_WEIGHT: pos = 3'd5;
            ST_SKIP:   pos = 3'd6;
            ST_CHECK:  pos = 3'd7;
            default:   pos = 3'd0;
        endcase
        return pos;
    endfunction

endpackage

// ===== sv/urfp_ram.sv =====
module urfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read (old data on a same-address write)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/uart_rx_ring_frame_parser_top.sv =====
// Receive ring and frame parser for a serial sensor link.
// Slave stream (i_s_*): one request per accepted beat. tuser[0] is the kind:
// a received serial byte (tdata holds it) or a consumer poll. A received
// byte goes into a RING_DEPTH-entry ring; a poll pops one byte, if the ring
// is not empty, into the frame parser (two header bytes, x, y, grip, weight,
// one skipped byte, checksum). There is no full check: RING_DEPTH unread
// bytes make the ring look empty again.
// Master stream (o_m_*): exactly one result per request, in order, with the
// stored frame fields, the pop flag, the parser position and the ack flag.
// o_m_tvalid rises in the cycle after acceptance. Throughput is one request
// per cycle unless the receiver stalls: the ring sits in a RAM with registered
// read whose address follows the next read index, so the head byte is always
// ready. A single output register holds the result; while the receiver
// stalls, o_s_tready stays high only in the cycle that result is taken.
// Reset (synchronous, i_rst_n low) empties the ring, returns the parser to
// the first header state, clears the stored fields and loads the default
// header bytes 'G' and 'O'. The ring contents need no clearing.
// The user makes configuration writes (i_cfg_*) only when the block is idle; the block does not enforce it.
module uart_rx_ring_frame_parser_top
    import urfp_pkg::*;
#(
    parameter int RING_DEPTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_addr,
    input  logic [BYTE_W-1:0]     i_cfg_data,
    // request stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // [7:0] rx_byte
    input  logic                  i_s_tuser,   // [0] op
    // result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [7:0] pos_x, [15:8] pos_y, [23:16] grip_level, [31:24] weight_level,
    // [39:32] frame_check, [40] byte_taken, [43:41] parse_position,
    // [44] ack_pulse, [47:45] zero
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

    logic [BYTE_W-1:0]     r_hdr_first;
    logic [BYTE_W-1:0]     r_hdr_second;
    logic [IDX_W-1:0]      r_wr_idx, n_wr_idx;
    logic [IDX_W-1:0]      r_rd_idx, n_rd_idx;
    t_frame_state          r_state, n_state;
    logic [BYTE_W-1:0]     r_pos_x, n_pos_x;
    logic [BYTE_W-1:0]     r_pos_y, n_pos_y;
    logic [BYTE_W-1:0]     r_grip, n_grip;
    logic [BYTE_W-1:0]     r_weight, n_weight;
    logic [BYTE_W-1:0]     r_check, n_check;
    logic                  r_byp_hit;
    logic [BYTE_W-1:0]     r_byp_data;
    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;

    logic                  in_fire;
    logic                  rx_wr;
    logic                  do_pop;
    logic                  n_ack;
    logic [BYTE_W-1:0]     ram_rdata;
    logic [BYTE_W-1:0]     head_byte;

    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    // handshake
    assign o_s_tready = !r_m_valid || i_m_tready;
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign rx_wr      = in_fire && (i_s_tuser == OP_RX_BYTE);
    assign do_pop     = in_fire && (i_s_tuser == OP_POLL) && (r_wr_idx != r_rd_idx);

    // ring indices
    assign n_wr_idx = rx_wr ? idx_next(r_wr_idx) : r_wr_idx;
    assign n_rd_idx = do_pop ? idx_next(r_rd_idx) : r_rd_idx;

    // ring storage, read address follows the next read index
    urfp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (rx_wr),
        .i_waddr (r_wr_idx),
        .i_wdata (i_s_tdata),
        .i_raddr (n_rd_idx),
        .o_rdata (ram_rdata)
    );

    // head byte, with bypass of a write to the entry being read
    assign head_byte = r_byp_hit ? r_byp_data : ram_rdata;

    // frame parser
    always_comb begin
        n_state  = r_state;
        n_pos_x  = r_pos_x;
        n_pos_y  = r_pos_y;
        n_grip   = r_grip;
        n_weight = r_weight;
        n_check  = r_check;
        n_ack    = 1'b0;
        if (do_pop) begin
            case (r_state)
                ST_HDR1: begin
                    n_state = (head_byte == r_hdr_first) ? ST_HDR2 : ST_HDR1;
                end
                ST_HDR2: begin
                    n_state = (head_byte == r_hdr_second) ? ST_X : ST_HDR1;
                end
                ST_X: begin
                    n_pos_x = head_byte;
                    n_state = ST_Y;
                end
                ST_Y: begin
                    n_pos_y = head_byte;
                    n_state = ST_GRIP;
                end
                ST_GRIP: begin
                    n_grip  = head_byte;
                    n_state = ST_WEIGHT;
                end
                ST_WEIGHT: begin
                    n_weight = head_byte;
                    n_ack    = 1'b1;
                    n_state  = ST_SKIP;
                end
                ST_SKIP: begin
                    n_state = ST_CHECK;
                end
                ST_CHECK: begin
                    n_check = head_byte;
                    n_state = ST_HDR1;
                end
                default: begin
                    n_state = ST_HDR1;
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_first  <= HEADER_FIRST_RST;
            r_hdr_second <= HEADER_SECOND_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_HEADER_FIRST:  r_hdr_first  <= i_cfg_data;
                CFG_HEADER_SECOND: r_hdr_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ring and parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx  <= '0;
            r_rd_idx  <= '0;
            r_state   <= ST_HDR1;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_grip    <= '0;
            r_weight  <= '0;
            r_check   <= '0;
            r_byp_hit <= 1'b0;
        end else begin
            r_wr_idx  <= n_wr_idx;
            r_rd_idx  <= n_rd_idx;
            r_state   <= n_state;
            r_pos_x   <= n_pos_x;
            r_pos_y   <= n_pos_y;
            r_grip    <= n_grip;
            r_weight  <= n_weight;
            r_check   <= n_check;
            r_byp_hit <= rx_wr && (r_wr_idx == n_rd_idx);
        end
    end

    // bypass data
    always_ff @(posedge i_clk) begin
        r_byp_data <= i_s_tdata;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (in_fire) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_m_data <= {3'b000, n_ack, state_pos(n_state), do_pop,
                         n_check, n_weight, n_grip, n_pos_y, n_pos_x};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule
